### src/eur_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package eur_pkg;

	localparam int COUNT_BITS = 27;
	localparam int CMP_W      = 34;
	localparam int IDX_W      = 3;
	localparam int CFG_DATA_W = 26;

	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

	localparam logic [1:0] ST_NODATA = 2'd0;
	localparam logic [1:0] ST_LOW    = 2'd1;
	localparam logic [1:0] ST_HIGH   = 2'd2;
	localparam logic [1:0] ST_GOOD   = 2'd3;

	localparam logic [IDX_W-1:0] REG_TRIGGER_TICKS = 3'd0;
	localparam logic [IDX_W-1:0] REG_CM_TICKS      = 3'd1;
	localparam logic [IDX_W-1:0] REG_MIN_CM        = 3'd2;
	localparam logic [IDX_W-1:0] REG_MAX_CM        = 3'd3;
	localparam logic [IDX_W-1:0] REG_ECHO_TIMEOUT  = 3'd4;
	localparam logic [IDX_W-1:0] REG_HOLDOFF       = 3'd5;
	localparam logic [IDX_W-1:0] REG_STARTUP       = 3'd6;

	typedef struct packed {
		logic [15:0] trigger_ticks;
		logic [15:0] cm_ticks;
		logic [9:0]  min_cm;
		logic [9:0]  max_cm;
		logic [23:0] echo_timeout_ticks;
		logic [23:0] holdoff_ticks;
		logic [25:0] startup_ticks;
	} cfg_t;

	typedef struct packed {
		logic        trigger_level;
		logic [9:0]  distance_cm;
		logic [1:0]  range_status;
		logic        measurement_done;
	} res_t;

	function automatic logic [CMP_W-1:0] cap_limit(input logic [CFG_DATA_W-1:0] lim);
		logic [CMP_W-1:0] l;
		logic [CMP_W-1:0] c;
		l = CMP_W'(lim);
		c = CMP_W'(CNT_MAX);
		return (l > c) ? c : l;
	endfunction

endpackage

`default_nettype wire

### src/eur_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module eur_cfg
	import eur_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [IDX_W-1:0]      cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                       cfg
);

	cfg_t cfg_q;
	logic wr;

	assign cfg_ready = 1'b1;
	assign wr        = cfg_valid && cfg_ready;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.trigger_ticks      <= 16'd3000;
			cfg_q.cm_ticks           <= 16'd11600;
			cfg_q.min_cm             <= 10'd2;
			cfg_q.max_cm             <= 10'd400;
			cfg_q.echo_timeout_ticks <= 24'd6960000;
			cfg_q.holdoff_ticks      <= 24'd4000000;
			cfg_q.startup_ticks      <= 26'd50000000;
		end else if (wr) begin
			unique case (cfg_index)
				REG_TRIGGER_TICKS: cfg_q.trigger_ticks      <= cfg_data[15:0];
				REG_CM_TICKS:      cfg_q.cm_ticks           <= cfg_data[15:0];
				REG_MIN_CM:        cfg_q.min_cm             <= cfg_data[9:0];
				REG_MAX_CM:        cfg_q.max_cm             <= cfg_data[9:0];
				REG_ECHO_TIMEOUT:  cfg_q.echo_timeout_ticks <= cfg_data[23:0];
				REG_HOLDOFF:       cfg_q.holdoff_ticks      <= cfg_data[23:0];
				REG_STARTUP:       cfg_q.startup_ticks      <= cfg_data;
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

### src/eur_core.sv
`timescale 1ns / 1ps
`default_nettype none

module eur_core
	import eur_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic acc,
	input  wire logic echo,
	input  cfg_t      cfg,
	output res_t      res
);

	localparam logic [2:0] PH_STARTUP = 3'd0;
	localparam logic [2:0] PH_TRIGGER = 3'd1;
	localparam logic [2:0] PH_WAIT    = 3'd2;
	localparam logic [2:0] PH_ECHO    = 3'd3;
	localparam logic [2:0] PH_HOLDOFF = 3'd4;

	logic [2:0]            phase_q, phase_d;
	logic [COUNT_BITS-1:0] tick_q, tick_d;
	logic [9:0]            cm_q, cm_d;
	logic [15:0]           frac_q, frac_d;
	logic [9:0]            dist_q, dist_d;
	logic [1:0]            stat_q, stat_d;
	logic                  done;

	logic [COUNT_BITS-1:0] tick_inc;
	logic [COUNT_BITS-1:0] b_tick, div_tick;
	logic [15:0]           b_frac, div_frac;
	logic [9:0]            b_cm, div_cm;
	logic [15:0]           dvs;
	logic                  frac_wrap;
	logic [25:0]           min_prod, max_prod;
	logic                  too_low, too_high;
	logic                  start_echo;
	logic [CMP_W-1:0]      tick_inc_w;
	logic                  hit_trig, hit_wait, hit_hold, hit_start;

	assign tick_inc   = (tick_q == CNT_MAX) ? tick_q : tick_q + 1'b1;
	assign tick_inc_w = CMP_W'(tick_inc);
	assign hit_trig   = tick_inc_w >= cap_limit(CFG_DATA_W'(cfg.trigger_ticks));
	assign hit_wait   = tick_inc_w >= cap_limit(CFG_DATA_W'(cfg.echo_timeout_ticks));
	assign hit_hold   = tick_inc_w >= cap_limit(CFG_DATA_W'(cfg.holdoff_ticks));
	assign hit_start  = tick_inc_w >= cap_limit(cfg.startup_ticks);

	assign dvs        = (cfg.cm_ticks == 16'd0) ? 16'd1 : cfg.cm_ticks;
	assign start_echo = (phase_q == PH_WAIT);
	assign b_tick     = start_echo ? '0 : tick_q;
	assign b_frac     = start_echo ? 16'd0 : frac_q;
	assign b_cm       = start_echo ? 10'd0 : cm_q;
	assign div_tick   = (b_tick == CNT_MAX) ? b_tick : b_tick + 1'b1;
	assign frac_wrap  = (17'(b_frac) + 17'd1) >= 17'(dvs);
	assign div_frac   = frac_wrap ? 16'd0 : b_frac + 16'd1;
	assign div_cm     = (frac_wrap && b_cm != 10'h3FF) ? b_cm + 10'd1 : b_cm;

	assign min_prod = 26'(cfg.min_cm) * 26'(dvs);
	assign max_prod = 26'(cfg.max_cm) * 26'(dvs);
	assign too_low  = CMP_W'(tick_q) < CMP_W'(min_prod);
	assign too_high = (tick_q == CNT_MAX) || (CMP_W'(tick_q) > CMP_W'(max_prod));

	always_comb begin
		phase_d = phase_q;
		tick_d  = tick_q;
		cm_d    = cm_q;
		frac_d  = frac_q;
		dist_d  = dist_q;
		stat_d  = stat_q;
		done    = 1'b0;
		unique case (phase_q)
			PH_TRIGGER: begin
				tick_d = tick_inc;
				if (hit_trig) begin
					phase_d = PH_WAIT;
					tick_d  = '0;
				end
			end
			PH_WAIT: begin
				if (echo) begin
					phase_d = PH_ECHO;
					tick_d  = div_tick;
					frac_d  = div_frac;
					cm_d    = div_cm;
				end else begin
					tick_d = tick_inc;
					if (hit_wait) begin
						dist_d  = 10'd0;
						stat_d  = ST_NODATA;
						done    = 1'b1;
						phase_d = PH_TRIGGER;
						tick_d  = '0;
					end
				end
			end
			PH_ECHO: begin
				if (echo) begin
					tick_d = div_tick;
					frac_d = div_frac;
					cm_d   = div_cm;
				end else begin
					if (too_low) begin
						dist_d = 10'd0;
						stat_d = ST_LOW;
					end else if (too_high) begin
						dist_d = 10'd0;
						stat_d = ST_HIGH;
					end else begin
						dist_d = cm_q;
						stat_d = ST_GOOD;
					end
					done    = 1'b1;
					phase_d = PH_HOLDOFF;
					tick_d  = '0;
					cm_d    = 10'd0;
					frac_d  = 16'd0;
				end
			end
			PH_HOLDOFF: begin
				tick_d = tick_inc;
				if (hit_hold) begin
					phase_d = PH_TRIGGER;
					tick_d  = '0;
				end
			end
			default: begin
				tick_d = tick_inc;
				if (hit_start) begin
					phase_d = PH_TRIGGER;
					tick_d  = '0;
				end
			end
		endcase
	end

	assign res.trigger_level    = (phase_q == PH_TRIGGER);
	assign res.distance_cm      = dist_d;
	assign res.range_status     = stat_d;
	assign res.measurement_done = done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_STARTUP;
			tick_q  <= '0;
			cm_q    <= 10'd0;
			frac_q  <= 16'd0;
			dist_q  <= 10'd0;
			stat_q  <= ST_NODATA;
		end else if (acc) begin
			phase_q <= phase_d;
			tick_q  <= tick_d;
			cm_q    <= cm_d;
			frac_q  <= frac_d;
			dist_q  <= dist_d;
			stat_q  <= stat_d;
		end
	end

	a_echo_end: assert property (@(posedge clk) disable iff (!arst_n)
		acc && phase_q == PH_ECHO && !echo |=> phase_q == PH_HOLDOFF && tick_q == '0)
		else $error("echo end did not enter holdoff");

	a_echo_start: assert property (@(posedge clk) disable iff (!arst_n)
		acc && phase_q == PH_WAIT && echo |=> phase_q == PH_ECHO && tick_q == COUNT_BITS'(1))
		else $error("echo start did not count first tick");

	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		acc && res.measurement_done |-> phase_q == PH_WAIT || phase_q == PH_ECHO)
		else $error("done outside wait or echo");

	a_hold_clear: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_HOLDOFF |-> cm_q == 10'd0 && frac_q == 16'd0)
		else $error("divider not cleared in holdoff");

endmodule

`default_nettype wire

### src/eur_out_buf.sv
`timescale 1ns / 1ps
`default_nettype none

module eur_out_buf
	import eur_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  res_t      push_data,
	output logic      full,
	output logic      out_valid,
	input  wire logic out_stall,
	output res_t      out_data
);

	logic out_valid_q;
	res_t out_data_q;
	logic skid_valid_q;
	res_t skid_data_q;
	logic take;

	assign take      = out_valid_q && !out_stall;
	assign full      = skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (take || !out_valid_q) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take || !out_valid_q) begin
			if (skid_valid_q) begin
				out_data_q <= skid_data_q;
			end else if (push) begin
				out_data_q <= push_data;
			end
		end else if (push) begin
			skid_data_q <= push_data;
		end
	end

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid holds a request while output is empty");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> !push)
		else $error("request pushed into full buffer");

	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		push && out_valid_q && out_stall |=> skid_valid_q && out_valid_q)
		else $error("held request lost");

endmodule

`default_nettype wire

### src/ultrasonic_echo_ranger_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Echo pulse timer for an ultrasonic range sensor. Every accepted request is one
// clock tick carrying the sampled echo pin; every request yields exactly one
// result with the trigger drive for that tick, the latest distance in cm and
// status, and a done flag on the tick a measurement or timeout completes. The
// block takes one request per clock unless echo_stall is high: all the work for
// a tick is done between the phase/counter registers and the output register.
// A two-entry output buffer lets a request in while a result waits;
// echo_stall rises only when both entries are full.
// Configuration registers are written through the cfg port, index 0 to 6 in
// the order trigger, cm_ticks, min_cm, max_cm, echo timeout, holdoff,
// startup; cfg_ready is always high.

module ultrasonic_echo_ranger_unit
	import eur_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  echo_valid,
	output logic                       echo_stall,
	input  wire logic                  echo_level,
	output logic                       result_valid,
	input  wire logic                  result_stall,
	output logic                       trigger_level,
	output logic [9:0]                 distance_cm,
	output logic [1:0]                 range_status,
	output logic                       measurement_done,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [IDX_W-1:0]      cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t cfg;
	res_t res;
	res_t out_data;
	logic full;
	logic acc;

	assign echo_stall = full;
	assign acc        = echo_valid && !full;

	eur_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	eur_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.acc    (acc),
		.echo   (echo_level),
		.cfg    (cfg),
		.res    (res)
	);

	eur_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (acc),
		.push_data (res),
		.full      (full),
		.out_valid (result_valid),
		.out_stall (result_stall),
		.out_data  (out_data)
	);

	assign trigger_level    = out_data.trigger_level;
	assign distance_cm      = out_data.distance_cm;
	assign range_status     = out_data.range_status;
	assign measurement_done = out_data.measurement_done;

endmodule

`default_nettype wire
